FILE: src/spm_pkg.sv
// ----------------------------------------------------------------------------
// spm_pkg
// Types, register map and shared helpers for the stereo peak meter.
// ----------------------------------------------------------------------------
package spm_pkg;

   localparam int unsigned CSR_ADDR_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH = 32;

   localparam logic CSR_IDX_DECAY_STEP  = 1'b0;
   localparam logic CSR_IDX_HOLD_FRAMES = 1'b1;

   localparam logic [6:0] DECAY_STEP_RESET  = 7'd2;
   localparam logic [5:0] HOLD_FRAMES_RESET = 6'd30;

   typedef struct packed {
      logic signed [15:0] sample_left;
      logic signed [15:0] sample_right;
      logic               frame_end;
   } req_payload_type;

   typedef struct packed {
      logic [6:0] level_left;
      logic [6:0] level_right;
      logic [7:0] hold_left;
      logic [7:0] hold_right;
   } rsp_payload_type;

   typedef struct packed {
      logic [7:0] mag_left;
      logic [7:0] mag_right;
      logic       frame_end;
   } mag_item_type;

   typedef struct packed {
      logic [6:0] decay_step;
      logic [5:0] hold_frames;
   } cfg_type;

   function automatic logic [7:0] byte_magnitude(input logic signed [15:0] sample);
      logic [7:0] hi;
      hi = sample[15:8];
      return hi[7] ? 8'(-hi) : hi;
   endfunction

   function automatic logic [6:0] decay_level(input logic [6:0] shown,
                                              input logic [6:0] level,
                                              input logic [6:0] step);
      logic signed [8:0] dec;
      dec = $signed({2'b00, shown}) - $signed({2'b00, step});
      if ((shown != 7'd0) && (dec > $signed({2'b00, level}))) begin
         return dec[6:0];
      end
      return level;
   endfunction

endpackage

FILE: src/stereo_peak_meter_with_hold.sv
// ----------------------------------------------------------------------------
// stereo_peak_meter_with_hold
// Stereo peak meter with per-frame decay and peak-hold markers.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_ready  req_payload (samples, frame_end)
// rsp       out        rsp_valid/rsp_ready  rsp_payload (levels, hold markers)
// csr       in         APB-style            decay_step at 0x0, hold_frames at 0x4
//
// One transaction can be accepted every cycle into the input register. The frame
// update is combinational and loads the result register at the next edge.
// A frame_end transaction passes through the input register and then the result register.
// Reset is synchronous and clears all meter state and the valid flags of both registers.
// A stalled result holds back the next frame_end transaction, and the input stops
// while that transaction waits in the input register.
// ----------------------------------------------------------------------------
module stereo_peak_meter_with_hold
   import spm_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_payload_type           req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_payload_type           rsp_payload,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready
);

   cfg_type      cfg;
   logic         take;
   logic         item_valid;
   mag_item_type item;

   spm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   spm_input_stage u_input_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .take        (take),
      .item_valid  (item_valid),
      .item        (item)
   );

   spm_frame_update u_frame_update (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .item_valid  (item_valid),
      .item        (item),
      .take        (take),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

FILE: src/spm_csr.sv
// ----------------------------------------------------------------------------
// spm_csr
// Register file for the decay step and the hold limit, APB-style access.
// ----------------------------------------------------------------------------
module spm_csr
   import spm_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready,
   output cfg_type                   cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr_en;
   logic    reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            CSR_IDX_DECAY_STEP:  cfg_in.decay_step  = csr_pwdata[6:0];
            CSR_IDX_HOLD_FRAMES: cfg_in.hold_frames = csr_pwdata[5:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         CSR_IDX_DECAY_STEP:  csr_prdata = {25'd0, cfg_ff.decay_step};
         CSR_IDX_HOLD_FRAMES: csr_prdata = {26'd0, cfg_ff.hold_frames};
         default:             csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.decay_step  <= DECAY_STEP_RESET;
         cfg_ff.hold_frames <= HOLD_FRAMES_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: src/spm_input_stage.sv
// ----------------------------------------------------------------------------
// spm_input_stage
// Input register holding the sample magnitudes of one transaction.
// ----------------------------------------------------------------------------
module spm_input_stage
   import spm_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   input  logic            take,
   output logic            item_valid,
   output mag_item_type    item
);

   logic         valid_ff;
   logic         valid_in;
   mag_item_type item_ff;
   mag_item_type item_in;
   logic         load;

   assign req_ready = !valid_ff || take;
   assign load      = req_valid && req_ready;

   always_comb begin
      item_in.mag_left  = byte_magnitude(req_payload.sample_left);
      item_in.mag_right = byte_magnitude(req_payload.sample_right);
      item_in.frame_end = req_payload.frame_end;
      if (load) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

FILE: src/spm_frame_update.sv
// ----------------------------------------------------------------------------
// spm_frame_update
// Frame peaks, decayed levels, hold markers, hold counter and result register.
// ----------------------------------------------------------------------------
module spm_frame_update
   import spm_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  logic            item_valid,
   input  mag_item_type    item,
   output logic            take,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   logic [7:0]      peak_l_ff, peak_r_ff, peak_l_in, peak_r_in;
   logic [6:0]      shown_l_ff, shown_r_ff, shown_l_in, shown_r_in;
   logic [7:0]      mark_l_ff, mark_r_ff, mark_l_in, mark_r_in;
   logic [5:0]      count_ff, count_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_ff, rsp_in;

   logic [7:0] peak_l, peak_r;
   logic [6:0] shown_l, shown_r;
   logic [6:0] count_inc;
   logic       expire;
   logic [7:0] mark_l_a, mark_r_a;
   logic [8:0] bar_l, bar_r;
   logic       hit_l, hit_r;
   logic       frame_done;

   assign take       = item_valid && (!item.frame_end || !rsp_valid_ff || rsp_ready);
   assign frame_done = take && item.frame_end;

   always_comb begin
      peak_l    = (item.mag_left > peak_l_ff) ? item.mag_left : peak_l_ff;
      peak_r    = (item.mag_right > peak_r_ff) ? item.mag_right : peak_r_ff;
      count_inc = {1'b0, count_ff} + 7'd1;
      expire    = count_inc > {1'b0, cfg.hold_frames};
      mark_l_a  = expire ? 8'd0 : mark_l_ff;
      mark_r_a  = expire ? 8'd0 : mark_r_ff;
      shown_l   = decay_level(shown_l_ff, peak_l[7:1], cfg.decay_step);
      shown_r   = decay_level(shown_r_ff, peak_r[7:1], cfg.decay_step);
      bar_l     = {shown_l, 2'b00};
      bar_r     = {shown_r, 2'b00};
      hit_l     = {1'b0, mark_l_a} < bar_l;
      hit_r     = {1'b0, mark_r_a} < bar_r;

      peak_l_in    = peak_l_ff;
      peak_r_in    = peak_r_ff;
      shown_l_in   = shown_l_ff;
      shown_r_in   = shown_r_ff;
      mark_l_in    = mark_l_ff;
      mark_r_in    = mark_r_ff;
      count_in     = count_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (frame_done) begin
         peak_l_in  = 8'd0;
         peak_r_in  = 8'd0;
         shown_l_in = shown_l;
         shown_r_in = shown_r;
         mark_l_in  = hit_l ? (bar_l[7:0] - 8'd4) : mark_l_a;
         mark_r_in  = hit_r ? (bar_r[7:0] - 8'd4) : mark_r_a;
         if (hit_l || hit_r) begin
            count_in = 6'd0;
         end else begin
            count_in = expire ? 6'd0 : count_inc[5:0];
         end
         rsp_in.level_left  = shown_l;
         rsp_in.level_right = shown_r;
         rsp_in.hold_left   = mark_l_in;
         rsp_in.hold_right  = mark_r_in;
         rsp_valid_in       = 1'b1;
      end else if (take) begin
         peak_l_in = peak_l;
         peak_r_in = peak_r;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_l_ff    <= 8'd0;
         peak_r_ff    <= 8'd0;
         shown_l_ff   <= 7'd0;
         shown_r_ff   <= 7'd0;
         mark_l_ff    <= 8'd0;
         mark_r_ff    <= 8'd0;
         count_ff     <= 6'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         peak_l_ff    <= peak_l_in;
         peak_r_ff    <= peak_r_in;
         shown_l_ff   <= shown_l_in;
         shown_r_ff   <= shown_r_in;
         mark_l_ff    <= mark_l_in;
         mark_r_ff    <= mark_r_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

FILE: src/spm_checker.sv
// ----------------------------------------------------------------------------
// spm_checker
// Port-level checks for the stereo peak meter, bound to the top level.
// ----------------------------------------------------------------------------
module spm_checker
   import spm_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_payload
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("Result transaction changed while stalled.");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("Result valid right after reset.");

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.level_left <= 7'd64) && (rsp_payload.level_right <= 7'd64))
      else $error("Level beyond full scale.");

   a_hold_grid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.hold_left[1:0] == 2'b00) && (rsp_payload.hold_left <= 8'd252)
         && (rsp_payload.hold_right[1:0] == 2'b00) && (rsp_payload.hold_right <= 8'd252))
      else $error("Hold marker off the bar grid.");

endmodule

bind stereo_peak_meter_with_hold spm_checker u_spm_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
